// File: design/gmf_pkg.sv
package gmf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_POINTS = 64;
    localparam int MAX_OFFSET = 32;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DIM_W   = 9;
    localparam int PIX_W   = 16;
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = 7;
    localparam int OFF_W   = $clog2(MAX_OFFSET) + 2;
    localparam int PROBE_W = COL_W + 2;
    localparam int RES_W   = 18;
    localparam int MODE_W  = 3;
    localparam int TYPE_W  = 2;
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_MODE          = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ELEMENT_COUNT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_DX     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_DY     = 3'd5;

    localparam logic [TYPE_W-1:0] REQ_PIXEL   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_POINT   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_COMPUTE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ERODE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DILATE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GRAD    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INNER   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OUTER   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LAPLACE = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic        [MODE_W-1:0] mode;
        logic        [DIM_W-1:0]  image_width;
        logic        [DIM_W-1:0]  image_height;
        logic        [CNT_W-1:0]  element_count;
        logic signed [OFF_W-1:0]  center_dx;
        logic signed [OFF_W-1:0]  center_dy;
    } cfg_t;

endpackage

// File: design/gmf_if.sv
interface gmf_req_if import gmf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic        [TYPE_W-1:0] req_type;
    logic        [COL_W-1:0]  col;
    logic        [ROW_W-1:0]  row;
    logic signed [PIX_W-1:0]  pixel_value;
    logic        [IDX_W-1:0]  point_index;
    logic signed [OFF_W-1:0]  point_dx;
    logic signed [OFF_W-1:0]  point_dy;

    modport source (
        output valid, req_type, col, row, pixel_value, point_index, point_dx, point_dy,
        input  ready
    );
    modport sink (
        input  valid, req_type, col, row, pixel_value, point_index, point_dx, point_dy,
        output ready
    );
endinterface

interface gmf_res_if import gmf_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_value;
    logic                    empty_res;

    modport source (
        output valid, result_value, empty_res,
        input  ready
    );
    modport sink (
        input  valid, result_value, empty_res,
        output ready
    );
endinterface

// File: design/gmf_ram.sv
module gmf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/gmf_cfg.sv
module gmf_cfg import gmf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:          cfg_next.mode          = pwdata[MODE_W-1:0];
                REG_IMAGE_WIDTH:   cfg_next.image_width   = pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = pwdata[DIM_W-1:0];
                REG_ELEMENT_COUNT: cfg_next.element_count = pwdata[CNT_W-1:0];
                REG_CENTER_DX:     cfg_next.center_dx     = pwdata[OFF_W-1:0];
                REG_CENTER_DY:     cfg_next.center_dy     = pwdata[OFF_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:          prdata = APB_DW'(cfg_reg.mode);
            REG_IMAGE_WIDTH:   prdata = APB_DW'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT:  prdata = APB_DW'(cfg_reg.image_height);
            REG_ELEMENT_COUNT: prdata = APB_DW'(cfg_reg.element_count);
            REG_CENTER_DX:     prdata = APB_DW'($unsigned(cfg_reg.center_dx));
            REG_CENTER_DY:     prdata = APB_DW'($unsigned(cfg_reg.center_dy));
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_ERODE;
            cfg_reg.image_width   <= DIM_W'(MAX_WIDTH);
            cfg_reg.image_height  <= DIM_W'(MAX_HEIGHT);
            cfg_reg.element_count <= '0;
            cfg_reg.center_dx     <= '0;
            cfg_reg.center_dy     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/gmf_scan.sv
module gmf_scan import gmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    gmf_req_if.sink     req,
    gmf_res_if.source   res
);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             x_wait_reg;
    logic signed [PIX_W-1:0] x_reg;
    logic             p1_vld_reg;
    logic             p2_vld_reg;
    logic             any_reg;
    logic             any_next;
    logic signed [PIX_W-1:0] lo_reg;
    logic signed [PIX_W-1:0] lo_next;
    logic signed [PIX_W-1:0] hi_reg;
    logic signed [PIX_W-1:0] hi_next;
    logic             res_vld_reg;
    logic             res_vld_next;
    logic signed [RES_W-1:0] res_value_reg;
    logic signed [RES_W-1:0] res_value_next;
    logic             res_empty_reg;
    logic             res_empty_next;

    logic             accept;
    logic             is_compute;
    logic             issue;
    logic             scan_done;
    logic             out_free;
    logic [CNT_W-1:0] n_pts;
    logic [DIM_W-1:0] w_lim;
    logic [DIM_W-1:0] h_lim;

    logic [2*OFF_W-1:0] off_wdata;
    logic [2*OFF_W-1:0] off_rdata;
    logic [PIX_W-1:0]   frame_rdata;
    logic               frame_we;
    logic               frame_re;
    logic [COL_W+ROW_W-1:0] frame_raddr;

    logic signed [OFF_W-1:0]   pdx;
    logic signed [OFF_W-1:0]   pdy;
    logic signed [PROBE_W-1:0] pc;
    logic signed [PROBE_W-1:0] pr;
    logic                      probe_in;
    logic signed [PIX_W-1:0]   v;

    logic signed [RES_W-1:0] lo_e;
    logic signed [RES_W-1:0] hi_e;
    logic signed [RES_W-1:0] x_e;
    logic signed [RES_W:0]   lap_sum;
    logic signed [RES_W-1:0] calc;

    assign accept     = req.valid & req.ready;
    assign req.ready  = (state_reg == ST_IDLE);
    assign is_compute = accept && (req.req_type == REQ_COMPUTE);

    assign n_pts = (cfg.element_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                           : cfg.element_count;
    assign w_lim = (cfg.image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                        : cfg.image_width;
    assign h_lim = (cfg.image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                          : cfg.image_height;

    assign issue     = (state_reg == ST_SCAN) && (cnt_reg < n_pts);
    assign scan_done = (state_reg == ST_SCAN) && !issue && !p1_vld_reg && !p2_vld_reg;
    assign out_free  = !res_vld_reg || res.ready;

    assign off_wdata = {req.point_dx, req.point_dy};

    gmf_ram #(
        .DEPTH (MAX_POINTS),
        .WIDTH (2*OFF_W)
    ) u_offset_ram (
        .clk   (clk),
        .we    (accept && (req.req_type == REQ_POINT)),
        .waddr (req.point_index),
        .wdata (off_wdata),
        .re    (issue),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (off_rdata)
    );

    assign pdx = off_rdata[2*OFF_W-1:OFF_W];
    assign pdy = off_rdata[OFF_W-1:0];
    assign pc  = {{(PROBE_W-COL_W){1'b0}}, col_reg} - PROBE_W'(cfg.center_dx)
                 + PROBE_W'(pdx);
    assign pr  = {{(PROBE_W-ROW_W){1'b0}}, row_reg} - PROBE_W'(cfg.center_dy)
                 + PROBE_W'(pdy);
    assign probe_in = p1_vld_reg
                      && !pc[PROBE_W-1] && ($unsigned(pc) < PROBE_W'(w_lim))
                      && !pr[PROBE_W-1] && ($unsigned(pr) < PROBE_W'(h_lim));

    assign frame_we    = accept && (req.req_type == REQ_PIXEL);
    assign frame_re    = is_compute || probe_in;
    assign frame_raddr = is_compute ? {req.row, req.col}
                                    : {pr[ROW_W-1:0], pc[COL_W-1:0]};

    gmf_ram #(
        .DEPTH (FRAME_DEPTH),
        .WIDTH (PIX_W)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .waddr ({req.row, req.col}),
        .wdata (req.pixel_value),
        .re    (frame_re),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    assign v = frame_rdata;

    always_comb
    begin
        any_next = any_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        if (is_compute)
        begin
            any_next = 1'b0;
        end
        else if (p2_vld_reg)
        begin
            any_next = 1'b1;
            if (!any_reg || (v < lo_reg))
            begin
                lo_next = v;
            end
            if (!any_reg || (v > hi_reg))
            begin
                hi_next = v;
            end
        end
    end

    assign lo_e    = RES_W'(lo_reg);
    assign hi_e    = RES_W'(hi_reg);
    assign x_e     = RES_W'(x_reg);
    assign lap_sum = (RES_W+1)'(lo_reg) + (RES_W+1)'(hi_reg) - ((RES_W+1)'(x_reg) <<< 1);

    always_comb
    begin
        unique case (cfg.mode)
            MODE_ERODE:   calc = lo_e;
            MODE_DILATE:  calc = hi_e;
            MODE_GRAD:    calc = hi_e - lo_e;
            MODE_INNER:   calc = x_e - lo_e;
            MODE_OUTER:   calc = hi_e - x_e;
            MODE_LAPLACE: calc = lap_sum[RES_W:1];
            default:      calc = lo_e;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        res_vld_next   = res_vld_reg;
        res_value_next = res_value_reg;
        res_empty_next = res_empty_reg;

        if (res_vld_reg && res.ready)
        begin
            res_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_compute)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_vld_next   = 1'b1;
                    res_value_next = any_reg ? calc : '0;
                    res_empty_next = !any_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            x_wait_reg  <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            any_reg     <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            x_wait_reg  <= is_compute;
            p1_vld_reg  <= issue;
            p2_vld_reg  <= probe_in;
            any_reg     <= any_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_compute)
        begin
            col_reg <= req.col;
            row_reg <= req.row;
        end
        if (x_wait_reg)
        begin
            x_reg <= frame_rdata;
        end
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        res_value_reg <= res_value_next;
        res_empty_reg <= res_empty_next;
    end

    assign res.valid        = res_vld_reg;
    assign res.result_value = res_value_reg;
    assign res.empty_res    = res_empty_reg;

`ifndef SYNTHESIS
    a_probe_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        p2_vld_reg |-> $past(p1_vld_reg))
        else $error("frame probe without an offset read");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (!p1_vld_reg && !p2_vld_reg))
        else $error("result formed with probes in flight");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_empty_reg) |-> (res_value_reg == '0))
        else $error("empty result carries a nonzero value");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= n_pts))
        else $error("point counter beyond element count");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(p1_vld_reg) |-> (state_reg != ST_IDLE))
        else $error("offset read while idle");
`endif

endmodule

// File: design/grayscale_morphology_filter.sv
// Channel   Kind        Direction  Payload
// req       valid/ready in         req_type, col, row, pixel_value, point_index,
//                                  point_dx, point_dy
// res       valid/ready out        result_value, empty_res
// apb       APB write   in         mode, image_width, image_height, element_count,
//                                  center_dx, center_dy
// Pixel and point writes leave the block ready; only a compute request takes it out of idle.
// A compute holds ready low until its result is registered; it reads the offset table once
// per element point, N = element_count capped at 64, and the frame store per in-image probe.
// Reset leaves the frame store and offset table unset; registers take their defaults.
// A finished result waits in the output register; the next request is taken meanwhile,
// and a compute only stalls at its end while that register is still full.
module grayscale_morphology_filter import gmf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    gmf_req_if.sink           req,
    gmf_res_if.source         res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;

    gmf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gmf_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .res   (res)
    );

endmodule

// File: tb/sv/morph_tb_pkg.sv
`timescale 1ns / 1ps

package morph_tb_pkg;
    import gmf_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic        [TYPE_W-1:0] kind;
        logic        [COL_W-1:0]  col;
        logic        [ROW_W-1:0]  row;
        logic signed [PIX_W-1:0]  pixel_value;
        logic        [IDX_W-1:0]  point_index;
        logic signed [OFF_W-1:0]  point_dx;
        logic signed [OFF_W-1:0]  point_dy;
    } morph_request_t;

    typedef struct packed {
        logic signed [RES_W-1:0] value;
        logic                    empty;
    } morph_result_t;

    class morphology_predictor;
        cfg_t                    cfg;
        logic signed [PIX_W-1:0] frame [FRAME_DEPTH];
        logic signed [OFF_W-1:0] offset_x [MAX_POINTS];
        logic signed [OFF_W-1:0] offset_y [MAX_POINTS];
        morph_result_t           expected_results [$];
        int                      errors;
        int                      computed;
        int                      empties;

        function new();
            cfg.mode          = MODE_ERODE;
            cfg.image_width   = DIM_W'(MAX_WIDTH);
            cfg.image_height  = DIM_W'(MAX_HEIGHT);
            cfg.element_count = '0;
            cfg.center_dx     = '0;
            cfg.center_dy     = '0;
            errors   = 0;
            computed = 0;
            empties  = 0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] index, logic [APB_DW-1:0] value);
            case (index)
                REG_MODE:          cfg.mode = value[MODE_W-1:0];
                REG_IMAGE_WIDTH:   cfg.image_width = value[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  cfg.image_height = value[DIM_W-1:0];
                REG_ELEMENT_COUNT: cfg.element_count = value[CNT_W-1:0];
                REG_CENTER_DX:     cfg.center_dx = value[OFF_W-1:0];
                REG_CENTER_DY:     cfg.center_dy = value[OFF_W-1:0];
                default: ;
            endcase
        endfunction

        function int eff_width();
            return (cfg.image_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg.image_width);
        endfunction

        function int eff_height();
            return (cfg.image_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg.image_height);
        endfunction

        function int eff_count();
            return (cfg.element_count > MAX_POINTS) ? MAX_POINTS : int'(cfg.element_count);
        endfunction

        function void probe(int k, int c, int r, output int pc, output int pr);
            pc = c - int'(signed'(cfg.center_dx)) + int'(offset_x[k]);
            pr = r - int'(signed'(cfg.center_dy)) + int'(offset_y[k]);
        endfunction

        function bit in_image(int pc, int pr);
            return pc >= 0 && pr >= 0 && pc < eff_width() && pr < eff_height();
        endfunction

        function morph_result_t filter_pixel(int c, int r);
            morph_result_t res;
            int            pc, pr, v, lo, hi, x, s;
            bit            found;
            found = 1'b0;
            lo = 0;
            hi = 0;
            for (int k = 0; k < eff_count(); k++) begin
                probe(k, c, r, pc, pr);
                if (!in_image(pc, pr))
                    continue;
                v = int'(frame[pr * MAX_WIDTH + pc]);
                if (!found) begin
                    lo = v;
                    hi = v;
                    found = 1'b1;
                end else begin
                    if (v < lo) lo = v;
                    if (v > hi) hi = v;
                end
            end
            if (!found) begin
                res.value = '0;
                res.empty = 1'b1;
                return res;
            end
            x = int'(frame[r * MAX_WIDTH + c]);
            case (cfg.mode)
                MODE_DILATE:  s = hi;
                MODE_GRAD:    s = hi - lo;
                MODE_INNER:   s = x - lo;
                MODE_OUTER:   s = hi - x;
                MODE_LAPLACE: s = (lo + hi - 2 * x) >>> 1;
                default:      s = lo;
            endcase
            res.value = RES_W'(s);
            res.empty = 1'b0;
            return res;
        endfunction

        function void note_request(morph_request_t q);
            case (q.kind)
                REQ_PIXEL: frame[int'(q.row) * MAX_WIDTH + int'(q.col)] = q.pixel_value;
                REQ_POINT: begin
                    offset_x[q.point_index] = q.point_dx;
                    offset_y[q.point_index] = q.point_dy;
                end
                REQ_COMPUTE: begin
                    expected_results.push_back(filter_pixel(int'(q.col), int'(q.row)));
                    computed++;
                    if (expected_results[$].empty) empties++;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [RES_W-1:0] value, logic empty);
            morph_result_t want;
            if (expected_results.size() == 0) begin
                $error("result_value: expected none, actual %0d (empty_res %0b)", value, empty);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (value !== want.value) begin
                $error("result_value: expected %0d, actual %0d", want.value, value);
                errors++;
            end
            if (empty !== want.empty) begin
                $error("empty_res: expected %0b, actual %0b", want.empty, empty);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

// File: tb/sv/tb_grayscale_morphology_filter.sv
`timescale 1ns / 1ps

module tb_grayscale_morphology_filter;
    import gmf_pkg::*;
    import morph_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int RANDOM_TARGET = 650;

    typedef struct packed {
        int mode;
        int width;
        int height;
        int count;
        int cdx;
        int cdy;
    } filter_setting_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    gmf_req_if req_bus();
    gmf_res_if res_bus();

    morphology_predictor morph_pred;

    bit pixel_loaded [FRAME_DEPTH];
    bit point_loaded [MAX_POINTS];
    bit gaps_on;
    bit stalls_on;
    int items_sent;
    int settings_used;
    int cycle_count;

    grayscale_morphology_filter u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .res     (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
            morph_pred.check_result(res_bus.result_value, res_bus.empty_res);
    end

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        int hold;
        hold = 0;
        res_bus.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                res_bus.ready = 1'b0;
                hold--;
            end else begin
                res_bus.ready = 1'b1;
                hold = pick_gap(stalls_on);
            end
        end
    end

    function automatic int pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return -32768;
        if (r < 20) return 32767;
        if (r < 25) return 0;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int pick_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return int'($urandom_range(0, 6)) - 3;
        if (r < 75) return ($urandom_range(0, 1) != 0) ? 32 : -32;
        return int'($urandom_range(0, 64)) - 32;
    endfunction

    function automatic int pick_position(int limit);
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, (limit + 2 > 255) ? 255 : limit + 2);
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_size();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 16);
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 255;
            2: return 256;
            3: return 300;
            default: return 511;
        endcase
    endfunction

    function automatic int pick_center();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return int'($urandom_range(0, 4)) - 2;
        if (r < 88) return -32;
        if (r < 96) return 32;
        return int'($urandom_range(0, 64)) - 32;
    endfunction

    function automatic filter_setting_t random_setting();
        filter_setting_t s;
        s.mode   = $urandom_range(0, 7);
        s.width  = pick_size();
        s.height = pick_size();
        if ($urandom_range(0, 9) < 8)
            s.count = $urandom_range(0, 12);
        else
            case ($urandom_range(0, 4))
                0: s.count = 0;
                1: s.count = 63;
                2: s.count = 64;
                3: s.count = 65;
                default: s.count = 127;
            endcase
        s.cdx = pick_center();
        s.cdy = pick_center();
        return s;
    endfunction

    function automatic filter_setting_t corner_setting(int i);
        case (i)
            0: return '{MODE_LAPLACE, 511, 511, 127, 32, -32};
            1: return '{MODE_GRAD, 256, 256, 64, -32, 32};
            2: return '{MODE_OUTER, 1, 1, 1, 0, 0};
            3: return '{7, 0, 5, 3, 0, 0};
            4: return '{6, 5, 0, 65, 1, 1};
            default: return '{MODE_DILATE, 300, 2, 63, -32, -32};
        endcase
    endfunction

    task automatic send_request(input logic [TYPE_W-1:0] kind, input int c, input int r,
                                input int value, input int index, input int dx, input int dy);
        morph_request_t item;
        int             gap;
        item.kind        = kind;
        item.col         = COL_W'(c);
        item.row         = ROW_W'(r);
        item.pixel_value = PIX_W'(value);
        item.point_index = IDX_W'(index);
        item.point_dx    = OFF_W'(dx);
        item.point_dy    = OFF_W'(dy);
        gap = pick_gap(gaps_on);
        if (gap > 0) begin
            @(negedge clk);
            req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_bus.req_type    = item.kind;
        req_bus.col         = item.col;
        req_bus.row         = item.row;
        req_bus.pixel_value = item.pixel_value;
        req_bus.point_index = item.point_index;
        req_bus.point_dx    = item.point_dx;
        req_bus.point_dy    = item.point_dy;
        req_bus.valid       = 1'b1;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        morph_pred.note_request(item);
        if (kind == REQ_PIXEL)
            pixel_loaded[int'(item.row) * MAX_WIDTH + int'(item.col)] = 1'b1;
        if (kind == REQ_POINT)
            point_loaded[item.point_index] = 1'b1;
        if (kind != REQ_RESERVED)
            items_sent++;
    endtask

    // load every offset and sample the compute will touch that is not yet loaded, then issue it
    task automatic compute_at(input int c, input int r);
        int pc, pr;
        for (int k = 0; k < morph_pred.eff_count(); k++)
            if (!point_loaded[k])
                send_request(REQ_POINT, $urandom, $urandom, $urandom, k,
                             pick_offset(), pick_offset());
        for (int k = 0; k < morph_pred.eff_count(); k++) begin
            morph_pred.probe(k, c, r, pc, pr);
            if (morph_pred.in_image(pc, pr) && !pixel_loaded[pr * MAX_WIDTH + pc])
                send_request(REQ_PIXEL, pc, pr, pick_sample(), $urandom, $urandom, $urandom);
        end
        if (!pixel_loaded[r * MAX_WIDTH + c])
            send_request(REQ_PIXEL, c, r, pick_sample(), $urandom, $urandom, $urandom);
        send_request(REQ_COMPUTE, c, r, $urandom, $urandom, $urandom, $urandom);
    endtask

    // hold requests until every result is back and the block has settled
    task automatic drain_requests();
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (morph_pred.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] index, input int value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        morph_pred.set_register(index, pwdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_setting(input filter_setting_t s);
        drain_requests();
        write_register(REG_MODE, s.mode);
        write_register(REG_IMAGE_WIDTH, s.width);
        write_register(REG_IMAGE_HEIGHT, s.height);
        write_register(REG_ELEMENT_COUNT, s.count);
        write_register(REG_CENTER_DX, s.cdx);
        write_register(REG_CENTER_DY, s.cdy);
        settings_used++;
    endtask

    task automatic run_phase(input int ops);
        int w, h, sel, c, r;
        w = morph_pred.eff_width();
        h = morph_pred.eff_height();
        for (int i = 0; i < ops && items_sent < RANDOM_TARGET; i++) begin
            sel = $urandom_range(0, 99);
            c = pick_position(w);
            r = pick_position(h);
            if (sel < 55)
                compute_at(c, r);
            else if (sel < 75)
                send_request(REQ_PIXEL, c, r, pick_sample(), $urandom, $urandom, $urandom);
            else if (sel < 90)
                send_request(REQ_POINT, $urandom, $urandom, $urandom,
                             $urandom_range(0, MAX_POINTS - 1), pick_offset(), pick_offset());
            else if (sel < 94)
                send_request(REQ_RESERVED, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
            else if (sel < 96)
                drain_requests();
            else
                compute_at(c, 0);
        end
    endtask

    initial
    begin
        int phase;
        morph_pred = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_PIXEL;
        req_bus.col = '0;
        req_bus.row = '0;
        req_bus.pixel_value = '0;
        req_bus.point_index = '0;
        req_bus.point_dx = '0;
        req_bus.point_dy = '0;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        items_sent = 0;
        settings_used = 0;
        cycle_count = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers at their defaults: no element points, so the result is empty
        compute_at(0, 0);
        send_request(REQ_RESERVED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_request(REQ_PIXEL, 0, 0, -32768, 0, 0, 0);
        send_request(REQ_PIXEL, 1, 0, 32767, 0, 0, 0);
        send_request(REQ_PIXEL, 0, 1, 0, 0, 0, 0);
        send_request(REQ_PIXEL, 1, 1, -1, 0, 0, 0);
        send_request(REQ_PIXEL, 255, 255, 32767, 0, 0, 0);
        send_request(REQ_POINT, 0, 0, 0, 0, 0, 0);
        send_request(REQ_POINT, 0, 0, 0, 1, 1, 0);
        send_request(REQ_POINT, 0, 0, 0, 2, 0, 1);
        send_request(REQ_POINT, 0, 0, 0, 3, 1, 1);
        send_request(REQ_POINT, 0, 0, 0, 4, -32, 32);
        send_request(REQ_POINT, 0, 0, 0, 5, 32, -32);
        for (int m = 0; m < 8; m++) begin
            apply_setting('{m, 2, 2, 6, 0, 0});
            compute_at(m % 2, 0);
        end
        apply_setting('{MODE_ERODE, 0, 2, 6, 0, 0});
        compute_at(255, 255);

        phase = 0;
        while (items_sent < RANDOM_TARGET) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (phase % 2 == 1) begin
                apply_setting(corner_setting((phase / 2) % 6));
                run_phase(12);
            end else begin
                apply_setting(random_setting());
                run_phase($urandom_range(25, 60));
            end
            phase++;
        end

        drain_requests();
        $display("Covered %0d requests in %0d register settings: %0d filter results, %0d empty",
                 items_sent, settings_used, morph_pred.computed, morph_pred.empties);
        if (morph_pred.errors == 0 && morph_pred.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
